[rtl/json_well_formed_checker_defines.svh]
// Assertion macros shared by the checker RTL.
`ifndef JSON_WELL_FORMED_CHECKER_DEFINES_SVH
`define JSON_WELL_FORMED_CHECKER_DEFINES_SVH
// Same-cycle implication under reset.
`define JWF_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication under reset.
`define JWF_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[rtl/jwf_pkg.sv]
// ----------------------------------------------------------------------------
// jwf_pkg
// Shared constants and types for the JSON well-formedness checker.
// ----------------------------------------------------------------------------
`default_nettype none
package jwf_pkg;
    localparam int MaxNestDefault = 16;

    typedef enum logic [1:0] {
        V_PENDING = 2'd0,
        V_GOOD    = 2'd1,
        V_BAD     = 2'd2
    } t_verdict;

    typedef enum logic [4:0] {
        M_START = 5'd0, M_BOM1 = 5'd1, M_BOM2 = 5'd2, M_VALUE = 5'd3,
        M_ARR1 = 5'd4, M_OBJ1 = 5'd5, M_OBJKEY = 5'd6, M_COLON = 5'd7,
        M_AFTER = 5'd8, M_KSTR = 5'd9, M_KESC = 5'd10, M_KHEX = 5'd11,
        M_VSTR = 5'd12, M_VESC = 5'd13, M_VHEX = 5'd14, M_LIT = 5'd15,
        M_NMINUS = 5'd16, M_NZERO = 5'd17, M_NINT = 5'd18, M_NDOT = 5'd19,
        M_NFRAC = 5'd20, M_NE = 5'd21, M_NESIGN = 5'd22, M_NEXP = 5'd23
    } t_mode;

    localparam logic [1:0] LIT_TRUE = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL = 2'd2;

    // Expected byte of a literal word at a position; zero where none is.
    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            LIT_TRUE: case (p)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'h00;
            endcase
            LIT_FALSE: case (p)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                3'd4: c = "e";
                default: c = 8'h00;
            endcase
            default: case (p)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'h00;
            endcase
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction
endpackage
`default_nettype wire

[rtl/jwf_stack.sv]
// ----------------------------------------------------------------------------
// jwf_stack
// Container kind stack: one bit per level, object when set, array when clear.
// ----------------------------------------------------------------------------
`default_nettype none
module jwf_stack
    import jwf_pkg::*;
#(
    parameter int MAX_NEST = MaxNestDefault,
    localparam int DW = $clog2(MAX_NEST + 1),
    localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic          i_kind,
    input  wire logic [DW-1:0] i_depth,
    output logic               o_top
);
    logic [MAX_NEST-1:0] r_kinds;
    logic [DW-1:0]       w_top_idx;

    assign w_top_idx = i_depth - DW'(1);
    assign o_top = (i_depth == '0) ? 1'b0 : r_kinds[w_top_idx[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kinds <= '0;
        end else if (i_push) begin
            r_kinds[i_depth[AW-1:0]] <= i_kind;
        end
    end
endmodule
`default_nettype wire

[rtl/json_well_formed_checker.sv]
// ----------------------------------------------------------------------------
// json_well_formed_checker
// Byte-serial JSON syntax checker with a bounded nesting stack.
// ----------------------------------------------------------------------------
// Usage: bytes of one text arrive on the input channel as transactions of
// i_ch with i_is_end low; a final transaction with i_is_end high closes it.
// Every input transaction produces exactly one output transaction: o_verdict
// is pending or malformed for bytes, and well-formed or malformed with
// o_finished high for the end transaction, after which the checker returns
// to its reset state ready for the next text.
// The byte is parsed in the cycle it is accepted and the verdict sits in the
// output register from the next cycle. Throughput is one transaction per
// cycle while the receiver keeps taking results, set by the single parse
// step with its stack read and push. When the receiver stalls, the output
// register holds and i_ready falls only while it is full and not being
// taken, so no result is lost. Reset (synchronous, active low) clears the
// scanner state, the nesting stack and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_well_formed_checker_defines.svh"
module json_well_formed_checker
    import jwf_pkg::*;
#(
    parameter int MAX_NEST = MaxNestDefault,
    localparam int DW = $clog2(MAX_NEST + 1)
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            i_ready,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_is_end,
    output logic            o_valid,
    input  wire logic       o_ready,
    output logic [1:0]      o_verdict,
    output logic            o_finished
);
    t_mode          r_mode, n_mode;
    logic [DW-1:0]  r_depth, n_depth;
    logic [2:0]     r_lit_p, n_lit_p;
    logic [1:0]     r_lit_k, n_lit_k;
    logic [2:0]     r_hex, n_hex;
    logic           r_failed, n_failed;
    logic           r_out_valid;
    logic [1:0]     r_verdict;
    logic           r_finished;

    logic           w_acc, w_top, w_push, w_kind;
    logic           w_ws, w_dig, w_hex, w_full;
    logic [7:0]     c;

    jwf_stack #(.MAX_NEST(MAX_NEST)) u_stack (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_kind(w_kind),
        .i_depth(r_depth), .o_top(w_top)
    );

    // The output register may take a new result whenever it is empty or
    // being drained in this cycle.
    assign i_ready = !r_out_valid || o_ready;
    assign w_acc = i_valid && i_ready;
    assign o_valid = r_out_valid;
    assign o_verdict = r_verdict;
    assign o_finished = r_finished;

    assign c = i_ch;
    assign w_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    assign w_dig = (c >= "0") && (c <= "9");
    assign w_hex = w_dig || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    assign w_full = (r_depth >= DW'(MAX_NEST));

    always_comb begin
        logic vs, af, str;
        logic [4:0] base;
        n_mode = r_mode; n_depth = r_depth; n_lit_p = r_lit_p; n_lit_k = r_lit_k;
        n_hex = r_hex; n_failed = r_failed; w_push = 1'b0; w_kind = 1'b0;
        vs = 1'b0; af = 1'b0; str = 1'b0; base = 5'd0;
        case (r_mode)
            M_START: begin
                if (c == 8'hEF) n_mode = M_BOM1;
                else if (w_ws) n_mode = M_VALUE;
                else vs = 1'b1;
            end
            M_BOM1: if (c == 8'hBB) n_mode = M_BOM2; else n_failed = 1'b1;
            M_BOM2: if (c == 8'hBF) n_mode = M_VALUE; else n_failed = 1'b1;
            M_VALUE: if (!w_ws) vs = 1'b1;
            M_ARR1: begin
                if (w_ws) begin
                end else if (c == "]") begin
                    n_depth = r_depth - DW'(1); n_mode = M_AFTER;
                end else vs = 1'b1;
            end
            M_OBJ1: begin
                if (w_ws) begin
                end else if (c == "}") begin
                    n_depth = r_depth - DW'(1); n_mode = M_AFTER;
                end else if (c == "\"") n_mode = M_KSTR;
                else n_failed = 1'b1;
            end
            M_OBJKEY: if (!w_ws) begin
                if (c == "\"") n_mode = M_KSTR; else n_failed = 1'b1;
            end
            M_COLON: if (!w_ws) begin
                if (c == ":") n_mode = M_VALUE; else n_failed = 1'b1;
            end
            M_AFTER: af = 1'b1;
            M_KSTR, M_KESC, M_KHEX: begin str = 1'b1; base = M_KSTR; end
            M_VSTR, M_VESC, M_VHEX: begin str = 1'b1; base = M_VSTR; end
            M_LIT: begin
                if (r_lit_p < lit_len(r_lit_k) && c == lit_char(r_lit_k, r_lit_p)) begin
                    n_lit_p = r_lit_p + 3'd1;
                    if (n_lit_p == lit_len(r_lit_k)) n_mode = M_AFTER;
                end else n_failed = 1'b1;
            end
            M_NMINUS: begin
                if (c == "0") n_mode = M_NZERO;
                else if (w_dig) n_mode = M_NINT;
                else n_failed = 1'b1;
            end
            M_NZERO, M_NINT, M_NFRAC: begin
                if (w_dig && r_mode != M_NZERO) begin
                end else if (c == "." && r_mode != M_NFRAC) n_mode = M_NDOT;
                else if (c == "e" || c == "E") n_mode = M_NE;
                else af = 1'b1;
            end
            M_NDOT: if (w_dig) n_mode = M_NFRAC; else n_failed = 1'b1;
            M_NE: begin
                if (c == "+" || c == "-") n_mode = M_NESIGN;
                else if (w_dig) n_mode = M_NEXP;
                else n_failed = 1'b1;
            end
            M_NESIGN: if (w_dig) n_mode = M_NEXP; else n_failed = 1'b1;
            M_NEXP: if (!w_dig) af = 1'b1;
            default: n_failed = 1'b1;
        endcase

        if (str) begin
            if (r_mode == t_mode'(base)) begin
                if (c == "\"") n_mode = (base == M_KSTR) ? M_COLON : M_AFTER;
                else if (c == "\\") n_mode = t_mode'(base + 5'd1);
                else if (c < 8'h20) n_failed = 1'b1;
            end else if (r_mode == t_mode'(base + 5'd1)) begin
                if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f"
                    || c == "n" || c == "r" || c == "t") n_mode = t_mode'(base);
                else if (c == "u") begin
                    n_hex = 3'd4; n_mode = t_mode'(base + 5'd2);
                end else n_failed = 1'b1;
            end else begin
                if (!w_hex) n_failed = 1'b1;
                else begin
                    n_hex = r_hex - 3'd1;
                    if (n_hex == 3'd0) n_mode = t_mode'(base);
                end
            end
        end

        if (vs) begin
            if (w_full) n_failed = 1'b1;
            else if (c == "{") begin
                w_push = 1'b1; w_kind = 1'b1; n_depth = r_depth + DW'(1); n_mode = M_OBJ1;
            end else if (c == "[") begin
                w_push = 1'b1; n_depth = r_depth + DW'(1); n_mode = M_ARR1;
            end else if (c == "\"") n_mode = M_VSTR;
            else if (c == "t") begin n_lit_k = LIT_TRUE; n_lit_p = 3'd1; n_mode = M_LIT; end
            else if (c == "f") begin n_lit_k = LIT_FALSE; n_lit_p = 3'd1; n_mode = M_LIT; end
            else if (c == "n") begin n_lit_k = LIT_NULL; n_lit_p = 3'd1; n_mode = M_LIT; end
            else if (c == "-") n_mode = M_NMINUS;
            else if (c == "0") n_mode = M_NZERO;
            else if (w_dig) n_mode = M_NINT;
            else n_failed = 1'b1;
        end

        if (af) begin
            n_mode = M_AFTER;
            if (w_ws) begin
            end else if (r_depth == '0) n_failed = 1'b1;
            else if (c == ",") n_mode = w_top ? M_OBJKEY : M_VALUE;
            else if ((c == "]" && !w_top) || (c == "}" && w_top))
                n_depth = r_depth - DW'(1);
            else n_failed = 1'b1;
        end

        // A stopped scanner must not touch the stack or its state.
        if (r_failed || !w_acc || i_is_end) begin
            n_mode = r_mode; n_depth = r_depth; n_lit_p = r_lit_p; n_lit_k = r_lit_k;
            n_hex = r_hex; n_failed = r_failed; w_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START; r_depth <= '0; r_lit_p <= '0; r_lit_k <= '0;
            r_hex <= '0; r_failed <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            // A held result stays until taken; a new one refills the register.
            r_out_valid <= w_acc || (r_out_valid && !o_ready);
            if (w_acc) begin
                if (i_is_end) begin
                    // The end transaction reports the final verdict and rearms.
                    r_mode <= M_START; r_depth <= '0; r_lit_p <= '0; r_lit_k <= '0;
                    r_hex <= '0; r_failed <= 1'b0;
                end else begin
                    r_mode <= n_mode; r_depth <= n_depth; r_lit_p <= n_lit_p;
                    r_lit_k <= n_lit_k; r_hex <= n_hex; r_failed <= n_failed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_finished <= i_is_end;
            if (i_is_end) begin
                r_verdict <= (!r_failed && r_depth == '0 &&
                    (r_mode == M_AFTER || r_mode == M_NZERO || r_mode == M_NINT ||
                     r_mode == M_NFRAC || r_mode == M_NEXP)) ? V_GOOD : V_BAD;
            end else begin
                r_verdict <= n_failed ? V_BAD : V_PENDING;
            end
        end
    end

    `JWF_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DW'(MAX_NEST))
    `JWF_ASSERT_NXT(a_end_rearms, i_clk, i_rst_n, w_acc && i_is_end, r_mode == M_START && r_depth == '0 && !r_failed)
    `JWF_ASSERT_NXT(a_fail_sticks, i_clk, i_rst_n, r_failed && !(w_acc && i_is_end), r_failed)
endmodule
`default_nettype wire

[test/json_well_formed_monitor.sv]
// ----------------------------------------------------------------------------
// json_well_formed_monitor
// Watches both channels of the JSON checker, predicts every verdict from
// its own model of the grammar scanner and compares each output transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module json_well_formed_monitor
    import jwf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_is_end,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [1:0] i_verdict,
    input  wire logic       i_finished,
    output int              o_errors,
    output int              o_pending
);
    localparam int NEST = MaxNestDefault;

    typedef struct packed {
        t_verdict verdict;
        logic     finished;
    } t_answer;

    t_answer verdict_q[$];

    t_mode      mode;
    logic       kinds[NEST];
    int         depth;
    int         lit_pos;
    int         lit_kind;
    int         hex_left;
    logic       bad;
    string      words[3] = '{"true", "false", "null"};

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_scanner();
        mode = M_START;
        foreach (kinds[k]) kinds[k] = 1'b0;
        depth = 0;
        lit_pos = 0;
        lit_kind = 0;
        hex_left = 0;
        bad = 1'b0;
    endfunction

    function automatic void open_value(logic [7:0] c);
        if (depth >= NEST) begin
            bad = 1'b1;
            return;
        end
        case (c)
            "{", "[": begin
                kinds[depth] = (c == "{");
                depth++;
                mode = (c == "{") ? M_OBJ1 : M_ARR1;
            end
            "\"": mode = M_VSTR;
            "t", "f", "n": begin
                lit_kind = (c == "t") ? 0 : (c == "f") ? 1 : 2;
                lit_pos = 1;
                mode = M_LIT;
            end
            "-": mode = M_NMINUS;
            "0": mode = M_NZERO;
            default: begin
                if (c >= "1" && c <= "9") mode = M_NINT;
                else bad = 1'b1;
            end
        endcase
    endfunction

    function automatic void after_value(logic [7:0] c);
        logic top;
        mode = M_AFTER;
        if (is_space(c)) return;
        if (depth == 0) begin
            bad = 1'b1;
            return;
        end
        top = kinds[depth - 1];
        if (c == ",") mode = top ? M_OBJKEY : M_VALUE;
        else if ((c == "]" && !top) || (c == "}" && top)) depth--;
        else bad = 1'b1;
    endfunction

    // One routine serves member names and string values; only the mode
    // returned to on the closing quote differs.
    function automatic void string_char(logic is_key, int sub, logic [7:0] c);
        t_mode body;
        body = is_key ? M_KSTR : M_VSTR;
        if (sub == 0) begin
            if (c == "\"") mode = is_key ? M_COLON : M_AFTER;
            else if (c == "\\") mode = is_key ? M_KESC : M_VESC;
            else if (c < 8'h20) bad = 1'b1;
        end else if (sub == 1) begin
            if (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t"}) begin
                mode = body;
            end else if (c == "u") begin
                hex_left = 4;
                mode = is_key ? M_KHEX : M_VHEX;
            end else begin
                bad = 1'b1;
            end
        end else begin
            if (!(is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"))) begin
                bad = 1'b1;
                return;
            end
            hex_left--;
            if (hex_left == 0) mode = body;
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        case (mode)
            M_KSTR, M_KESC, M_KHEX: string_char(1'b1, int'(mode) - int'(M_KSTR), c);
            M_VSTR, M_VESC, M_VHEX: string_char(1'b0, int'(mode) - int'(M_VSTR), c);
            M_START: begin
                if (c == 8'hEF) mode = M_BOM1;
                else if (is_space(c)) mode = M_VALUE;
                else open_value(c);
            end
            M_BOM1: if (c == 8'hBB) mode = M_BOM2; else bad = 1'b1;
            M_BOM2: if (c == 8'hBF) mode = M_VALUE; else bad = 1'b1;
            M_VALUE: if (!is_space(c)) open_value(c);
            M_ARR1: begin
                if (c == "]") begin
                    depth--;
                    mode = M_AFTER;
                end else if (!is_space(c)) begin
                    open_value(c);
                end
            end
            M_OBJ1: begin
                if (c == "}") begin
                    depth--;
                    mode = M_AFTER;
                end else if (c == "\"") begin
                    mode = M_KSTR;
                end else if (!is_space(c)) begin
                    bad = 1'b1;
                end
            end
            M_OBJKEY: begin
                if (c == "\"") mode = M_KSTR;
                else if (!is_space(c)) bad = 1'b1;
            end
            M_COLON: begin
                if (c == ":") mode = M_VALUE;
                else if (!is_space(c)) bad = 1'b1;
            end
            M_AFTER: after_value(c);
            M_LIT: begin
                if (lit_pos < words[lit_kind].len() && c == words[lit_kind][lit_pos]) begin
                    lit_pos++;
                    if (lit_pos == words[lit_kind].len()) mode = M_AFTER;
                end else begin
                    bad = 1'b1;
                end
            end
            M_NMINUS: begin
                if (c == "0") mode = M_NZERO;
                else if (c >= "1" && c <= "9") mode = M_NINT;
                else bad = 1'b1;
            end
            M_NZERO, M_NINT, M_NFRAC: begin
                if (is_num(c) && mode != M_NZERO) begin
                    // more digits of the same part
                end else if (c == "." && mode != M_NFRAC) begin
                    mode = M_NDOT;
                end else if (c == "e" || c == "E") begin
                    mode = M_NE;
                end else begin
                    after_value(c);
                end
            end
            M_NDOT: if (is_num(c)) mode = M_NFRAC; else bad = 1'b1;
            M_NE: begin
                if (c == "+" || c == "-") mode = M_NESIGN;
                else if (is_num(c)) mode = M_NEXP;
                else bad = 1'b1;
            end
            M_NESIGN: if (is_num(c)) mode = M_NEXP; else bad = 1'b1;
            M_NEXP: if (!is_num(c)) after_value(c);
            default: bad = 1'b1;
        endcase
    endfunction

    function automatic t_answer judge(logic [7:0] c, logic last);
        t_answer a;
        logic complete;
        if (last) begin
            complete = mode inside {M_AFTER, M_NZERO, M_NINT, M_NFRAC, M_NEXP};
            a.verdict = (!bad && complete && depth == 0) ? V_GOOD : V_BAD;
            a.finished = 1'b1;
            clear_scanner();
        end else begin
            if (!bad) scan_byte(c);
            a.verdict = bad ? V_BAD : V_PENDING;
            a.finished = 1'b0;
        end
        return a;
    endfunction

    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        t_answer want;
        int      fails;
        fails = 0;
        if (!i_rst_n) begin
            clear_scanner();
            verdict_q.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, verdict %0d finished %0b",
                             $time, i_verdict, i_finished);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_verdict !== want.verdict) begin
                        $display("%0t: verdict expected %0d actual %0d",
                                 $time, want.verdict, i_verdict);
                        fails++;
                    end
                    if (i_finished !== want.finished) begin
                        $display("%0t: finished expected %0b actual %0b",
                                 $time, want.finished, i_finished);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) verdict_q.push_back(judge(i_ch, i_is_end));
            o_errors <= o_errors + fails;
        end
    end
endmodule
`default_nettype wire

[test/json_well_formed_checker_tb.sv]
// ----------------------------------------------------------------------------
// json_well_formed_checker_tb
// Feeds the JSON checker with hand-written texts and random generated ones.
// ----------------------------------------------------------------------------
// The random texts are mostly well-formed JSON with random content, deep
// nesting now and then, and a share of damaged texts and raw noise. The
// sender works in bursts with gaps, and the receiver stalls on its own
// cycle-driven pattern. A separate monitor predicts and checks every
// transaction; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module json_well_formed_checker_tb;
    import jwf_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int BYTE_TARGET = 950;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_ready;
    logic [7:0] i_ch = 8'h00;
    logic       i_is_end = 1'b0;
    logic       o_valid;
    logic       o_ready = 1'b0;
    logic [1:0] o_verdict;
    logic       o_finished;

    int         errors;
    int         pending;
    int         idle_cycles = 0;
    int         burst_left = 0;
    logic       steady = 1'b0;
    int         bytes_sent = 0;
    logic [9:0] stall_phase = '0;
    logic [7:0] text[$];

    always #2 i_clk = ~i_clk;

    json_well_formed_checker i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_ready   (i_ready),
        .i_ch      (i_ch),
        .i_is_end  (i_is_end),
        .o_valid   (o_valid),
        .o_ready   (o_ready),
        .o_verdict (o_verdict),
        .o_finished(o_finished)
    );

    json_well_formed_monitor i_monitor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_ready (i_ready),
        .i_ch       (i_ch),
        .i_is_end   (i_is_end),
        .i_out_valid(o_valid),
        .i_out_ready(o_ready),
        .i_verdict  (o_verdict),
        .i_finished (o_finished),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // The receiver cycles through four moods: always ready, coin-flip,
    // mostly ready, and a regular pattern that stalls for most of each period.
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0: o_ready <= 1'b1;
            2'd1: o_ready <= 1'($urandom_range(0, 1));
            2'd2: o_ready <= ($urandom_range(0, 7) != 0);
            default: o_ready <= (stall_phase[3:0] < 4'd5);
        endcase
    end

    // The watchdog ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && i_ready) || (o_valid && o_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Presents one transaction at a falling edge and returns at the falling
    // edge after it was taken, so valid stays high across back-to-back items.
    task automatic send_item(input logic [7:0] c, input logic last);
        if (burst_left == 0) begin
            if (!steady) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        i_is_end <= last;
        @(posedge i_clk);
        while (!i_ready) @(posedge i_clk);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text[k]) send_item(text[k], 1'b0);
        // The byte lane carries junk on the end transaction; it must be ignored.
        send_item(8'($urandom), 1'b1);
        bytes_sent += text.size() + 1;
        text.delete();
    endtask

    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++) text.push_back(s[k]);
    endfunction

    function automatic void add_space();
        logic [7:0] blanks[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) text.push_back(blanks[$urandom_range(0, 3)]);
    endfunction

    function automatic void add_hex();
        string hex = "0123456789abcdefABCDEF";
        text.push_back(hex[$urandom_range(0, 21)]);
    endfunction

    // Strings mix printable text, every simple escape, four-digit hex
    // escapes and bytes above 0x7F, which are passed without UTF-8 checks.
    function automatic void add_string();
        string esc = "\"\\/bfnrt";
        text.push_back("\"");
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 5))
                0: begin
                    text.push_back("\\");
                    text.push_back(esc[$urandom_range(0, 7)]);
                end
                1: begin
                    add_str("\\u");
                    repeat (4) add_hex();
                end
                2: text.push_back(8'($urandom_range(8'h80, 8'hFF)));
                default: begin
                    logic [7:0] c;
                    c = 8'($urandom_range(8'h20, 8'h7E));
                    if (c == "\"" || c == "\\") c = "a";
                    text.push_back(c);
                end
            endcase
        end
        text.push_back("\"");
    endfunction

    function automatic void add_number();
        if ($urandom_range(0, 2) == 0) text.push_back("-");
        if ($urandom_range(0, 3) == 0) begin
            text.push_back("0");
        end else begin
            text.push_back(8'($urandom_range("1", "9")));
            repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 2) == 0) begin
            text.push_back(".");
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 2) == 0) begin
            text.push_back($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0: text.push_back("+");
                1: text.push_back("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) text.push_back(8'($urandom_range("0", "9")));
        end
    endfunction

    // A random value whose opening byte sits at nesting level lvl.
    function automatic void add_value(int lvl);
        int n;
        int pick;
        pick = (lvl < 3) ? $urandom_range(0, 6) : $urandom_range(2, 6);
        n = $urandom_range(0, 3);
        case (pick)
            0, 1: begin
                text.push_back(pick == 0 ? "[" : "{");
                add_space();
                for (int k = 0; k < n; k++) begin
                    if (k > 0) begin
                        text.push_back(",");
                        add_space();
                    end
                    if (pick == 1) begin
                        add_string();
                        add_space();
                        text.push_back(":");
                        add_space();
                    end
                    add_value(lvl + 1);
                    add_space();
                end
                text.push_back(pick == 0 ? "]" : "}");
            end
            2: add_string();
            3: add_str("true");
            4: add_str("false");
            5: add_str("null");
            default: add_number();
        endcase
    endfunction

    // A chain of containers around the nesting limit, closed by an empty
    // container, a scalar or nothing at all.
    function automatic void add_deep();
        int levels;
        levels = $urandom_range(MaxNestDefault - 2, MaxNestDefault + 1);
        for (int k = 0; k < levels; k++) add_str(k[0] ? "{\"k\":" : "[");
        case ($urandom_range(0, 2))
            0: add_str("[]");
            1: add_str("7");
            default: ;
        endcase
        for (int k = levels - 1; k >= 0; k--) add_str(k[0] ? "}" : "]");
    endfunction

    function automatic void make_random_text();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 5) == 0) begin
            text.push_back(8'hEF);
            text.push_back(8'hBB);
            text.push_back(8'hBF);
        end
        add_space();
        if (kind == 1) add_deep();
        else add_value(0);
        add_space();
        // About a quarter of the texts get damaged in one way.
        if (kind >= 15 && text.size() > 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    int at;
                    at = $urandom_range(0, text.size() - 1);
                    text[at] = text[at] ^ (8'h01 << $urandom_range(0, 7));
                end
                1: repeat ($urandom_range(1, 3)) if (text.size() > 0) void'(text.pop_back());
                default: text.insert($urandom_range(0, text.size()), 8'($urandom));
            endcase
        end
    endfunction

    initial begin
        string directed[$];
        directed = '{
            "{\"a\" : [1, -0.5e+10, 2E-3, 0], \"b\":{}, \"c\":\"x\\n\\u00aF\"}",
            "true", "false", " null\t\r\n", "tru", "nulx", "01", "-", "1.", "1e+",
            "[1 2]", "1 2", "{\"a\" 1}", "[1,]", "\"open", "\"bad\\q\"", "\"\\u12G4\"",
            "[[[[[[[[[[[[[[[[]]]]]]]]]]]]]]]]", "[[[[[[[[[[[[[[[[1]]]]]]]]]]]]]]]]",
            "[[[[[[[[[[[[[[[[[", ""
        };
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) begin
            add_str(directed[k]);
            send_text();
        end
        // Byte order mark handling, raw zero, control and high bytes.
        text = '{8'hEF, 8'hBB, 8'hBF, "[", "]"};
        send_text();
        text = '{8'hEF, 8'hBB, "1"};
        send_text();
        text = '{8'h20, 8'hEF, 8'hBB, 8'hBF, "1"};
        send_text();
        text = '{"\"", 8'h00, "\""};
        send_text();
        text = '{"\"", 8'h1F, "\""};
        send_text();
        text = '{"\"", 8'hFF, 8'h80, "\""};
        send_text();
        text = '{8'hFF};
        send_text();

        while (bytes_sent < BYTE_TARGET) begin
            steady = ($urandom_range(0, 4) == 0);
            make_random_text();
            send_text();
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
